### sv/psp_pixel_pressure_convert_top_macros.svh
// Assertion helpers for the pixel pressure converter
`ifndef PSP_PIXEL_PRESSURE_CONVERT_TOP_MACROS_SVH
`define PSP_PIXEL_PRESSURE_CONVERT_TOP_MACROS_SVH

// ante implies cons in the same cycle, ignored during reset
`define PPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle, also checked across reset
`define PPC_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ppc_pkg.sv
`timescale 1ns / 1ps
package ppc_pkg;

    localparam int RATIO_W = 24;
    localparam int PRES_W  = 32;
    localparam int COEF_W  = 24;
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;

    localparam logic [CIDX_W-1:0] CFG_COEF_CONST   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_COEF_LINEAR  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_COEF_SQUARE  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RATIO_SCALE  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_STATIC       = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_INV_DYNAMIC  = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_MASK_ENABLE  = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_TWO_COMP     = 3'd7;

    // classified pixel: dividend, divisor and flags
    typedef struct packed {
        logic [47:0] num;
        logic [31:0] den;
        logic        zdiv;
        logic        masked;
    } t_item;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               zdiv;
        logic               masked;
    } t_div_res;

    typedef struct packed {
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [17:0] scale;
        logic [31:0] stat;
        logic [31:0] invdyn;
    } t_calib_cfg;

endpackage

### sv/ppc_front.sv
`timescale 1ns / 1ps
module ppc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mask_enable,
    input  logic                        i_two_component,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ppc_pkg::PIX_W-1:0]   i_off_sensitive,
    input  logic [ppc_pkg::PIX_W-1:0]   i_on_sensitive,
    input  logic [ppc_pkg::PIX_W-1:0]   i_off_reference,
    input  logic [ppc_pkg::PIX_W-1:0]   i_on_reference,
    input  logic                        i_q_full,
    output logic                        o_push,
    output ppc_pkg::t_item              o_item
);
    import ppc_pkg::*;

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [31:0] prod_num;
    logic [31:0] prod_den;

    assign prod_num = i_off_sensitive * i_on_reference;
    assign prod_den = i_on_sensitive * i_off_reference;

    always_comb begin
        n_item.masked = i_mask_enable && (i_off_sensitive == '0);
        if (i_two_component) begin
            n_item.num  = {prod_num, 16'b0};
            n_item.den  = prod_den;
            n_item.zdiv = (i_on_sensitive == '0) || (i_off_reference == '0)
                          || (i_on_reference == '0);
        end else begin
            n_item.num  = {16'b0, i_off_sensitive, 16'b0};
            n_item.den  = {16'b0, i_on_sensitive};
            n_item.zdiv = (i_on_sensitive == '0);
        end
    end

    assign o_in_stall = r_valid && i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### sv/ppc_queue.sv
`timescale 1ns / 1ps
module ppc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ppc_pkg::t_item o_item
);
    import ppc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### sv/ppc_div.sv
`timescale 1ns / 1ps
module ppc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ppc_pkg::t_item    i_item,
    output logic              o_valid,
    output ppc_pkg::t_div_res o_res
);
    import ppc_pkg::*;

    localparam int NST = RATIO_W;

    logic               r_valid  [NST+1];
    logic [31:0]        r_rem    [NST+1];
    logic [RATIO_W-1:0] r_q      [NST+1];
    logic [RATIO_W-1:0] r_lo     [NST+1];
    logic [31:0]        r_den    [NST+1];
    logic               r_sat    [NST+1];
    logic               r_zdiv   [NST+1];
    logic               r_masked [NST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    // quotient overflows 24 bits when num >= den * 2^24
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]    <= {8'b0, i_item.num[47:24]};
            r_lo[0]     <= i_item.num[23:0];
            r_q[0]      <= '0;
            r_den[0]    <= i_item.den;
            r_sat[0]    <= {8'b0, i_item.num} >= {i_item.den, 24'b0};
            r_zdiv[0]   <= i_item.zdiv;
            r_masked[0] <= i_item.masked;
        end
    end

    for (genvar k = 1; k <= NST; k++) begin : g_stage
        logic [32:0] trial;
        logic        ge;
        logic [32:0] diff;

        assign trial = {r_rem[k-1], r_lo[k-1][NST-k]};
        assign ge    = trial >= {1'b0, r_den[k-1]};
        assign diff  = trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]    <= ge ? diff[31:0] : trial[31:0];
                r_q[k]      <= {r_q[k-1][RATIO_W-2:0], ge};
                r_lo[k]     <= r_lo[k-1];
                r_den[k]    <= r_den[k-1];
                r_sat[k]    <= r_sat[k-1];
                r_zdiv[k]   <= r_zdiv[k-1];
                r_masked[k] <= r_masked[k-1];
            end
        end
    end

    assign o_valid      = r_valid[NST];
    assign o_res.zdiv   = r_zdiv[NST];
    assign o_res.masked = r_masked[NST];
    assign o_res.ratio  = (r_zdiv[NST] || r_masked[NST]) ? '0 :
                          r_sat[NST] ? '1 : r_q[NST];

endmodule

### sv/ppc_calib.sv
`timescale 1ns / 1ps
module ppc_calib (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  ppc_pkg::t_calib_cfg         i_cfg,
    input  logic                        i_valid,
    input  ppc_pkg::t_div_res           i_res,
    output logic                        o_valid,
    output logic [ppc_pkg::RATIO_W-1:0] o_light_ratio,
    output logic signed [ppc_pkg::PRES_W-1:0] o_pressure,
    output logic signed [ppc_pkg::COEF_W-1:0] o_pressure_coeff,
    output logic                        o_zero_divisor
);
    import ppc_pkg::*;

    localparam int NST = 7;

    logic               r_valid [NST];
    t_div_res           r_side  [NST];

    logic [41:0]        scaled;
    logic [51:0]        isq_full;
    logic signed [58:0] lin;
    logic signed [64:0] plo;
    logic signed [36:0] phi;
    logic [69:0]        sum;
    logic [45:0]        sum_sh;
    logic [31:0]        n_p;
    logic [32:0]        diff;
    logic signed [65:0] cprod;
    logic [49:0]        cp_sh;
    logic [39:0]        cp_neg;
    logic [23:0]        n_cp;

    logic [25:0]        r1_ival;
    logic [35:0]        r2_isq;
    logic [58:0]        r2_lin;
    logic [58:0]        r3_lin;
    logic [64:0]        r3_plo;
    logic [36:0]        r3_phi;
    logic [69:0]        r4_sum;
    logic [31:0]        r5_p;
    logic [31:0]        r6_p;
    logic [65:0]        r6_prod;
    logic [23:0]        r7_cp;
    logic [31:0]        r7_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    assign scaled   = i_res.ratio * i_cfg.scale;
    assign isq_full = r1_ival * r1_ival;
    assign lin      = $signed(i_cfg.a1) * $signed({1'b0, r1_ival});
    assign plo      = $signed(i_cfg.a2) * $signed({1'b0, r2_isq[31:0]});
    assign phi      = $signed(i_cfg.a2) * $signed({1'b0, r2_isq[35:32]});
    assign sum      = {{22{i_cfg.a0[31]}}, i_cfg.a0, 16'b0}
                    + {{11{r3_lin[58]}}, r3_lin}
                    + {{5{r3_plo[64]}}, r3_plo}
                    + {r3_phi[36], r3_phi, 32'b0};
    assign sum_sh   = r4_sum[69:24];

    always_comb begin
        if (r_side[3].masked) begin
            n_p = '0;
        end else if (&sum_sh[45:31] || ~|sum_sh[45:31]) begin
            n_p = sum_sh[31:0];
        end else if (sum_sh[45]) begin
            n_p = 32'h8000_0000;
        end else begin
            n_p = 32'h7FFF_FFFF;
        end
    end

    assign diff   = {r5_p[31], r5_p} - {i_cfg.stat[31], i_cfg.stat};
    assign cprod  = $signed(diff) * $signed({1'b0, i_cfg.invdyn});
    assign cp_sh  = r6_prod[65:16];
    assign cp_neg = {r6_p, 8'b0};

    always_comb begin
        if (!r6_p[31] && (r6_p != '0)) begin
            if (&cp_sh[49:23] || ~|cp_sh[49:23]) begin
                n_cp = cp_sh[23:0];
            end else begin
                n_cp = cp_sh[49] ? 24'h80_0000 : 24'h7F_FFFF;
            end
        end else begin
            if (&cp_neg[39:23] || ~|cp_neg[39:23]) begin
                n_cp = cp_neg[23:0];
            end else begin
                n_cp = 24'h80_0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_res;
            for (int s = 1; s < NST; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r1_ival <= scaled[41:16];
            r2_isq  <= isq_full[51:16];
            r2_lin  <= lin;
            r3_lin  <= r2_lin;
            r3_plo  <= plo;
            r3_phi  <= phi;
            r4_sum  <= sum;
            r5_p    <= n_p;
            r6_p    <= r5_p;
            r6_prod <= cprod;
            r7_cp   <= n_cp;
        end
    end

    // pressure delayed one stage to line up with the coefficient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_p <= r6_p;
        end
    end

    assign o_valid          = r_valid[NST-1];
    assign o_light_ratio    = r_side[NST-1].ratio;
    assign o_zero_divisor   = r_side[NST-1].zdiv;
    assign o_pressure       = r7_p;
    assign o_pressure_coeff = r7_cp;

endmodule

### sv/psp_pixel_pressure_convert_top.sv
`timescale 1ns / 1ps
// From input accept to result: the front register, the queue, the 25-stage divider
// (input stage plus 24 quotient bits) and 7 calibration stages. Throughput: one item per
// cycle unless the output stalls; a 4-entry queue (QUEUE_DEPTH) decouples front and back.
// Reset: synchronous active low; clears valids, queue, and config to defaults.
`include "psp_pixel_pressure_convert_top_macros.svh"
module psp_pixel_pressure_convert_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ppc_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [ppc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ppc_pkg::PIX_W-1:0]         i_off_sensitive,
    input  logic [ppc_pkg::PIX_W-1:0]         i_on_sensitive,
    input  logic [ppc_pkg::PIX_W-1:0]         i_off_reference,
    input  logic [ppc_pkg::PIX_W-1:0]         i_on_reference,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ppc_pkg::RATIO_W-1:0]       o_light_ratio,
    output logic signed [ppc_pkg::PRES_W-1:0] o_pressure,
    output logic signed [ppc_pkg::COEF_W-1:0] o_pressure_coeff,
    output logic                              o_zero_divisor
);
    import ppc_pkg::*;

    t_calib_cfg r_cfg;
    logic       r_mask_enable;
    logic       r_two_component;

    logic       push;
    logic       q_full;
    logic       q_valid;
    t_item      front_item;
    t_item      q_item;
    logic       back_en;
    logic       div_valid;
    t_div_res   div_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.a0        <= '0;
            r_cfg.a1        <= '0;
            r_cfg.a2        <= '0;
            r_cfg.scale     <= 18'd65536;
            r_cfg.stat      <= '0;
            r_cfg.invdyn    <= 32'd16777216;
            r_mask_enable   <= 1'b0;
            r_two_component <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COEF_CONST:  r_cfg.a0        <= i_cfg_data;
                CFG_COEF_LINEAR: r_cfg.a1        <= i_cfg_data;
                CFG_COEF_SQUARE: r_cfg.a2        <= i_cfg_data;
                CFG_RATIO_SCALE: r_cfg.scale     <= i_cfg_data[17:0];
                CFG_STATIC:      r_cfg.stat      <= i_cfg_data;
                CFG_INV_DYNAMIC: r_cfg.invdyn    <= i_cfg_data;
                CFG_MASK_ENABLE: r_mask_enable   <= i_cfg_data[0];
                CFG_TWO_COMP:    r_two_component <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign back_en = !(o_out_valid && i_out_stall);

    ppc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mask_enable   (r_mask_enable),
        .i_two_component (r_two_component),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_off_sensitive (i_off_sensitive),
        .i_on_sensitive  (i_on_sensitive),
        .i_off_reference (i_off_reference),
        .i_on_reference  (i_on_reference),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_item          (front_item)
    );

    ppc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (back_en),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    ppc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_valid (div_valid),
        .o_res   (div_res)
    );

    ppc_calib u_calib (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (back_en),
        .i_cfg            (r_cfg),
        .i_valid          (div_valid),
        .i_res            (div_res),
        .o_valid          (o_out_valid),
        .o_light_ratio    (o_light_ratio),
        .o_pressure       (o_pressure),
        .o_pressure_coeff (o_pressure_coeff),
        .o_zero_divisor   (o_zero_divisor)
    );

    `PPC_ASSERT_NOW(a_zdiv_ratio, i_clk, i_rst_n, o_out_valid && o_zero_divisor, o_light_ratio == '0, "ratio not zero on zero divisor")
    `PPC_ASSERT_NOW(a_zero_pres, i_clk, i_rst_n, o_out_valid && (o_pressure == '0), o_pressure_coeff == '0, "coefficient not zero for zero pressure")
    `PPC_ASSERT_NOW(a_neg_pres, i_clk, i_rst_n, o_out_valid && o_pressure[31], o_pressure_coeff[23], "coefficient not negative for negative pressure")
    `PPC_ASSERT_NEXT(a_rst_idle, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "outputs active after reset")

endmodule

### tb/psp_pixel_pressure_convert_top_test.sv
`timescale 1ns / 1ps
module psp_pixel_pressure_convert_top_test;
    import ppc_pkg::*;

    localparam int LATENCY    = 33;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_LEN   = 200;
    localparam longint PLIM   = 64'sd4611686018427387904;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [PRES_W-1:0]  pres;
        logic [COEF_W-1:0]  coef;
        logic               zdiv;
    } t_pixel_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    logic [PIX_W-1:0] i_off_sensitive;
    logic [PIX_W-1:0] i_on_sensitive;
    logic [PIX_W-1:0] i_off_reference;
    logic [PIX_W-1:0] i_on_reference;
    logic o_out_valid;
    logic i_out_stall;
    logic [RATIO_W-1:0] o_light_ratio;
    logic signed [PRES_W-1:0] o_pressure;
    logic signed [COEF_W-1:0] o_pressure_coeff;
    logic o_zero_divisor;

    psp_pixel_pressure_convert_top u_top (.*);

    // model copy of the calibration registers
    logic signed [31:0] m_a0, m_a1, m_a2, m_stat;
    logic [17:0] m_scale;
    logic [31:0] m_invdyn;
    logic m_mask, m_two;

    t_pixel_res pending_q[$];
    int  n_errors = 0;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_req;
    int  hold_seen;
    int  hold_left;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic longint mul_sat(longint x, longint y);
        longint m;
        longint r;
        m = (x < 0) ? -x : x;
        if (m == 0 || y == 0) return 0;
        if (m > PLIM / y) r = PLIM;
        else r = m * y;
        if (r > PLIM) r = PLIM;
        return (x < 0) ? -r : r;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_pixel_res convert_pixel(logic [15:0] off, logic [15:0] on,
                                                 logic [15:0] off2, logic [15:0] on2);
        t_pixel_res res;
        logic [63:0] ratio;
        logic [63:0] ival;
        logic [63:0] isq;
        longint sum;
        longint p;
        longint cp;
        logic zd;
        logic msk;
        ratio = 0;
        msk = m_mask && (off == 0);
        if (m_two) begin
            zd = (on == 0) || (off2 == 0) || (on2 == 0);
            if (!zd) ratio = ((64'(off) * on2) << 16) / (64'(on) * off2);
        end else begin
            zd = (on == 0);
            if (!zd) ratio = (64'(off) << 16) / on;
        end
        if (ratio > 64'hFFFFFF) ratio = 64'hFFFFFF;
        if (msk) ratio = 0;
        ival = (ratio * m_scale) >> 16;
        isq = (ival * ival) >> 16;
        sum = longint'(m_a0) * 65536 + mul_sat(longint'(m_a1), longint'(ival))
            + mul_sat(longint'(m_a2), longint'(isq));
        p = sat(sum >>> 24, -64'sd2147483648, 64'sd2147483647);
        if (msk) p = 0;
        if (p > 0) cp = mul_sat(p - longint'(m_stat), longint'({32'd0, m_invdyn})) >>> 16;
        else cp = p * 256;
        cp = sat(cp, -64'sd8388608, 64'sd8388607);
        res.ratio = ratio[23:0];
        res.pres = p[31:0];
        res.coef = cp[23:0];
        res.zdiv = zd;
        return res;
    endfunction

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COEF_CONST:  m_a0 = val;
            CFG_COEF_LINEAR: m_a1 = val;
            CFG_COEF_SQUARE: m_a2 = val;
            CFG_RATIO_SCALE: m_scale = val[17:0];
            CFG_STATIC:      m_stat = val;
            CFG_INV_DYNAMIC: m_invdyn = val;
            CFG_MASK_ENABLE: m_mask = val[0];
            CFG_TWO_COMP:    m_two = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] off, logic [15:0] on,
                              logic [15:0] off2, logic [15:0] on2);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_off_sensitive <= off;
        i_on_sensitive <= on;
        i_off_reference <= off2;
        i_on_reference <= on2;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_q.insert(pending_q.size(), convert_pixel(off, on, off2, on2));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_pix();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_regs(bit extreme);
        if (extreme) begin
            write_reg(CFG_COEF_CONST, $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000);
            write_reg(CFG_COEF_LINEAR, $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000);
            write_reg(CFG_COEF_SQUARE, $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000);
            write_reg(CFG_RATIO_SCALE, $urandom_range(1) ? 32'h3FFFF : 32'h0);
            write_reg(CFG_STATIC, $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000);
            write_reg(CFG_INV_DYNAMIC, $urandom_range(1) ? 32'hFFFFFFFF : 32'h0);
        end else begin
            write_reg(CFG_COEF_CONST, $urandom);
            write_reg(CFG_COEF_LINEAR, $urandom >>> $urandom_range(31));
            write_reg(CFG_COEF_SQUARE, $urandom >>> $urandom_range(31));
            write_reg(CFG_RATIO_SCALE, $urandom_range(262143));
            write_reg(CFG_STATIC, $urandom);
            write_reg(CFG_INV_DYNAMIC, $urandom);
        end
        write_reg(CFG_MASK_ENABLE, $urandom_range(1));
        write_reg(CFG_TWO_COMP, $urandom_range(1));
    endtask

    task automatic test_directed();
        write_reg(CFG_COEF_CONST, 32'h00010000);
        write_reg(CFG_COEF_LINEAR, 32'h00020000);
        write_reg(CFG_COEF_SQUARE, 32'hFFFF0000);
        send_pixel(16'd100, 16'd50, 16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'd1, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'd0, 16'd0);
        send_pixel(16'd5, 16'd0, 16'd0, 16'd0);
        drain();
        write_reg(CFG_MASK_ENABLE, 32'd1);
        write_reg(CFG_TWO_COMP, 32'd1);
        send_pixel(16'd0, 16'd7, 16'd3, 16'd4);
        send_pixel(16'd0, 16'd0, 16'd3, 16'd4);
        send_pixel(16'd9, 16'd7, 16'd0, 16'd4);
        send_pixel(16'd9, 16'd7, 16'd3, 16'd0);
        send_pixel(16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
        send_pixel(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
        send_pixel(16'd300, 16'd200, 16'd100, 16'd120);
        drain();
        for (int i = 0; i < 4; i++) begin
            random_regs(1'b1);
            send_pixel(16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
            send_pixel(16'd1234, 16'd999, 16'd4321, 16'd3210);
            send_pixel(16'd0, 16'd1, 16'd1, 16'd1);
            drain();
        end
    endtask

    task automatic test_random(int n_sets, int per_set);
        for (int s = 0; s < n_sets; s++) begin
            random_regs(s % 5 == 0);
            for (int i = 0; i < per_set; i++)
                send_pixel(rand_pix(), rand_pix(), rand_pix(), rand_pix());
            drain();
        end
    endtask

    task automatic test_backpressure();
        random_regs(1'b0);
        hold_req = hold_req + 1;
        for (int i = 0; i < 60; i++)
            send_pixel(rand_pix(), rand_pix(), rand_pix(), rand_pix());
        drain();
        for (int i = 0; i < 20; i++)
            send_pixel(rand_pix(), rand_pix(), rand_pix(), rand_pix());
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 20; i++)
            send_pixel(rand_pix(), rand_pix(), rand_pix(), rand_pix());
        drain();
    endtask

    // receiver stall: random, or one long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            hold_left <= 0;
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_res exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected item ratio=%h pres=%h coef=%h zdiv=%b", $time,
                         o_light_ratio, o_pressure, o_pressure_coeff, o_zero_divisor);
                n_errors++;
            end else begin
                exp_res = pending_q.pop_front();
                if (o_light_ratio !== exp_res.ratio) begin
                    $display("%0t: light_ratio expected %h actual %h", $time,
                             exp_res.ratio, o_light_ratio);
                    n_errors++;
                end
                if (o_pressure !== exp_res.pres) begin
                    $display("%0t: pressure expected %h actual %h", $time,
                             exp_res.pres, o_pressure);
                    n_errors++;
                end
                if (o_pressure_coeff !== exp_res.coef) begin
                    $display("%0t: pressure_coeff expected %h actual %h", $time,
                             exp_res.coef, o_pressure_coeff);
                    n_errors++;
                end
                if (o_zero_divisor !== exp_res.zdiv) begin
                    $display("%0t: zero_divisor expected %b actual %b", $time,
                             exp_res.zdiv, o_zero_divisor);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        hold_req = 0;
        send_idle_pct = 27;
        recv_idle_pct = 84;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_off_sensitive = '0;
        i_on_sensitive = '0;
        i_off_reference = '0;
        i_on_reference = '0;
        m_a0 = 0;
        m_a1 = 0;
        m_a2 = 0;
        m_scale = 18'd65536;
        m_stat = 0;
        m_invdyn = 32'd16777216;
        m_mask = 1'b0;
        m_two = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(10, 50);
        send_idle_pct = 84;
        recv_idle_pct = 27;
        test_random(10, 50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(10, 50);
        test_backpressure();
        drain();
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
